/* design/sce_pkg.sv */
// ----------------------------------------------------------------------------
// sce_pkg
// types, register codes, state codes and the arctangent table of the
// stroke corner extractor
// ----------------------------------------------------------------------------
package sce_pkg;

  localparam int unsigned CoordBits = 16;
  localparam int unsigned CordBits  = 44;
  localparam int unsigned CordSteps = 30;

  typedef struct packed {
    logic signed [CoordBits-1:0] pt_x;
    logic signed [CoordBits-1:0] pt_y;
    logic                        pt_last;
  } in_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] out_x;
    logic signed [CoordBits-1:0] out_y;
    logic                        out_last;
  } out_t;

  localparam logic [1:0] RegThreshold = 2'd0;
  localparam logic [1:0] RegSnapSize  = 2'd1;
  localparam logic [1:0] RegClosure   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HEAD,
    S_ANG1,
    S_ANG2,
    S_CORNER,
    S_MID,
    S_CLA,
    S_CLB,
    S_CLC,
    S_TAIL
  } top_state_e;

  typedef enum logic [1:0] {
    C_IDLE,
    C_NORM,
    C_ROT,
    C_DONE
  } cord_state_e;

  localparam logic [31:0] ATAN_TAB [0:CordSteps-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

endpackage

/* design/sce_cordic.sv */
// ----------------------------------------------------------------------------
// sce_cordic
// iterative direction unit: normalize, then one vectoring step per cycle
// ----------------------------------------------------------------------------
module sce_cordic #(
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [sce_pkg::CoordBits:0]   dx_i,
  input  logic signed [sce_pkg::CoordBits:0]   dy_i,
  output logic                                 done_o,
  output logic [ANGLE_BITS-1:0]                angle_o
);

  localparam int unsigned XW = sce_pkg::CordBits;

  sce_pkg::cord_state_e state_q, state_d;
  logic signed [XW-1:0] x_q, x_d, y_q, y_d;
  logic [31:0] z_q, z_d;
  logic [4:0]  i_q, i_d;

  logic signed [XW-1:0] xs, ys, xi, yi;
  logic [XW-1:0] ax, ay, m;
  logic ypos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sce_pkg::C_IDLE;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  always_comb begin
    xi   = XW'(dx_i);
    yi   = XW'(dy_i);
    ax   = x_q[XW-1] ? XW'(-x_q) : XW'(x_q);
    ay   = y_q[XW-1] ? XW'(-y_q) : XW'(y_q);
    m    = (ax > ay) ? ax : ay;
    xs   = x_q >>> i_q;
    ys   = y_q >>> i_q;
    ypos = !y_q[XW-1] && (y_q != '0);
    state_d = state_q;
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    i_d = i_q;
    unique case (state_q) inside
      sce_pkg::C_IDLE, sce_pkg::C_DONE: begin
        state_d = sce_pkg::C_IDLE;
        if (start_i) begin
          if (dx_i == '0 && dy_i == '0) begin
            z_d = 32'h0;
            state_d = sce_pkg::C_DONE;
          end else if (dy_i == '0) begin
            z_d = dx_i[sce_pkg::CoordBits] ? 32'h80000000 : 32'h0;
            state_d = sce_pkg::C_DONE;
          end else if (dx_i == '0) begin
            z_d = dy_i[sce_pkg::CoordBits] ? 32'hC0000000 : 32'h40000000;
            state_d = sce_pkg::C_DONE;
          end else begin
            x_d = dx_i[sce_pkg::CoordBits] ? XW'(-xi) : xi;
            y_d = dx_i[sce_pkg::CoordBits] ? XW'(-yi) : yi;
            z_d = dx_i[sce_pkg::CoordBits] ? 32'h80000000 : 32'h0;
            state_d = sce_pkg::C_NORM;
          end
        end
      end
      sce_pkg::C_NORM: begin
        i_d = '0;
        if (m[XW-1:40] != '0) begin
          state_d = sce_pkg::C_ROT;
        end else if (m[XW-1:36] == '0) begin
          x_d = x_q <<< 4;
          y_d = y_q <<< 4;
        end else begin
          x_d = x_q <<< 1;
          y_d = y_q <<< 1;
        end
      end
      sce_pkg::C_ROT: begin
        if (ypos) begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + sce_pkg::ATAN_TAB[i_q];
        end else begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - sce_pkg::ATAN_TAB[i_q];
        end
        i_d = i_q + 5'd1;
        if (i_q == 5'(sce_pkg::CordSteps - 1)) state_d = sce_pkg::C_DONE;
      end
      default: state_d = sce_pkg::C_IDLE;
    endcase
  end

  assign done_o  = (state_q == sce_pkg::C_DONE);
  assign angle_o = z_q[31 -: ANGLE_BITS];

endmodule

/* design/stroke_corner_extractor_top.sv */
// ----------------------------------------------------------------------------
// stroke_corner_extractor_top
// emits the corner points of a pen stroke
// ----------------------------------------------------------------------------
// Pen points enter on in_data_i under in_valid_i / in_stall_o; a request is
// taken when valid is high and stall is low. Corner points leave on
// out_data_o under out_valid_o / out_stall_i. Registers are written on the
// cfg channel (index 0 threshold, 1 snap size, 2 closure enable) whenever
// cfg_valid_i is high; cfg_ready_o is always high.
// One point is processed at a time and in_stall_o stays high until its
// results are delivered. The first point of a stroke also waits for the
// output handshakes; the second does not use the cordic unit. Later points
// run two directions through the shared cordic unit: a zero or axis
// direction skips the normalize and rotation steps, any other is
// normalized, rotated and then reported done. Such a point keeps in_stall_o
// high through both directions, a corner output, the closure test on a
// closing point and the output handshakes. A stalled receiver holds the
// block in the current output state with the payload unchanged. Reset
// empties the stroke and restores threshold 30, snap size 32 and closure on.
// ----------------------------------------------------------------------------
module stroke_corner_extractor_top #(
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sce_pkg::in_t        in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sce_pkg::out_t       out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [10:0]         cfg_data_i
);

  localparam int unsigned CW = sce_pkg::CoordBits;

  sce_pkg::top_state_e state_q, state_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [8:0]  thr_q;
  logic [10:0] snap_q;
  logic        clos_q;

  logic [CW-1:0] px_q, px_d, py_q, py_d, fx_q, fx_d, fy_q, fy_d;
  logic [CW-1:0] ax_q, ax_d, ay_q, ay_d, mx_q, mx_d, my_q, my_d;
  logic          plast_q, plast_d;
  logic [ANGLE_BITS-1:0] a1_q, a1_d;
  sce_pkg::out_t out_q, out_d;
  logic [20:0] acc_q, acc_d;

  logic in_acc, out_acc;
  logic cord_start, cord_done;
  logic signed [CW:0] cdx, cdy, fdx, fdy;
  logic [ANGLE_BITS-1:0] cord_ang, adiff;
  logic [ANGLE_BITS+8:0] d360, thr_sh;
  logic corner;
  logic [CW:0] adx, ady;
  logic [9:0]  half, mop;
  logic [19:0] prod;
  logic far;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != sce_pkg::S_IDLE);
  assign out_valid_o = (state_q == sce_pkg::S_HEAD) || (state_q == sce_pkg::S_CORNER) ||
                       (state_q == sce_pkg::S_TAIL);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= 9'd30;
      snap_q <= 11'd32;
      clos_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sce_pkg::RegThreshold: thr_q  <= cfg_data_i[8:0];
        sce_pkg::RegSnapSize:  snap_q <= cfg_data_i;
        sce_pkg::RegClosure:   clos_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sce_pkg::S_IDLE;
      cnt_q   <= '0;
      fx_q <= '0; fy_q <= '0; ax_q <= '0; ay_q <= '0; mx_q <= '0; my_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      fx_q <= fx_d; fy_q <= fy_d; ax_q <= ax_d; ay_q <= ay_d;
      mx_q <= mx_d; my_q <= my_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q    <= px_d;
    py_q    <= py_d;
    plast_q <= plast_d;
    a1_q    <= a1_d;
    out_q   <= out_d;
    acc_q   <= acc_d;
  end

  sce_cordic #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .dx_i    (cdx),
    .dy_i    (cdy),
    .done_o  (cord_done),
    .angle_o (cord_ang)
  );

  always_comb begin
    if (state_q == sce_pkg::S_IDLE) begin
      cdx = $signed({mx_q[CW-1], mx_q}) - $signed({ax_q[CW-1], ax_q});
      cdy = $signed({my_q[CW-1], my_q}) - $signed({ay_q[CW-1], ay_q});
    end else begin
      cdx = $signed({px_q[CW-1], px_q}) - $signed({mx_q[CW-1], mx_q});
      cdy = $signed({py_q[CW-1], py_q}) - $signed({my_q[CW-1], my_q});
    end
    cord_start = (in_acc && cnt_q >= 3'd2) || (state_q == sce_pkg::S_ANG1 && cord_done);
    adiff  = (a1_q > cord_ang) ? a1_q - cord_ang : cord_ang - a1_q;
    d360   = ({9'd0, adiff} << 8) + ({9'd0, adiff} << 6) + ({9'd0, adiff} << 5) +
             ({9'd0, adiff} << 3);
    thr_sh = {thr_q, {ANGLE_BITS{1'b0}}};
    corner = (d360 >= thr_sh);
    fdx  = $signed({px_q[CW-1], px_q}) - $signed({fx_q[CW-1], fx_q});
    fdy  = $signed({py_q[CW-1], py_q}) - $signed({fy_q[CW-1], fy_q});
    adx  = fdx[CW] ? (CW+1)'(-fdx) : (CW+1)'(fdx);
    ady  = fdy[CW] ? (CW+1)'(-fdy) : (CW+1)'(fdy);
    half = snap_q[10:1];
    far  = (adx >= (CW+1)'(half)) || (ady >= (CW+1)'(half));
    case (state_q)
      sce_pkg::S_CLA: mop = adx[9:0];
      sce_pkg::S_CLB: mop = ady[9:0];
      default:        mop = half;
    endcase
    prod = mop * mop;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    px_d = px_q; py_d = py_q; plast_d = plast_q;
    fx_d = fx_q; fy_d = fy_q; ax_d = ax_q; ay_d = ay_q; mx_d = mx_q; my_d = my_q;
    a1_d  = a1_q;
    out_d = out_q;
    acc_d = acc_q;
    unique case (state_q)
      sce_pkg::S_IDLE: begin
        if (in_acc) begin
          px_d    = in_data_i.pt_x;
          py_d    = in_data_i.pt_y;
          plast_d = in_data_i.pt_last;
          if (cnt_q == 3'd0) begin
            fx_d = in_data_i.pt_x; ax_d = in_data_i.pt_x;
            fy_d = in_data_i.pt_y; ay_d = in_data_i.pt_y;
            out_d = '{out_x: in_data_i.pt_x, out_y: in_data_i.pt_y, out_last: 1'b0};
            cnt_d = in_data_i.pt_last ? 3'd0 : 3'd1;
            state_d = sce_pkg::S_HEAD;
          end else if (cnt_q == 3'd1) begin
            state_d = sce_pkg::S_MID;
          end else begin
            state_d = sce_pkg::S_ANG1;
          end
        end
      end
      sce_pkg::S_HEAD: begin
        if (out_acc) begin
          if (plast_q) begin
            out_d.out_last = 1'b1;
            state_d = sce_pkg::S_TAIL;
          end else begin
            state_d = sce_pkg::S_IDLE;
          end
        end
      end
      sce_pkg::S_ANG1: begin
        if (cord_done) begin
          a1_d = cord_ang;
          state_d = sce_pkg::S_ANG2;
        end
      end
      sce_pkg::S_ANG2: begin
        if (cord_done) begin
          if (corner) begin
            out_d = '{out_x: mx_q, out_y: my_q, out_last: 1'b0};
            ax_d = mx_q;
            ay_d = my_q;
            state_d = sce_pkg::S_CORNER;
          end else begin
            state_d = sce_pkg::S_MID;
          end
        end
      end
      sce_pkg::S_CORNER: begin
        if (out_acc) state_d = sce_pkg::S_MID;
      end
      sce_pkg::S_MID: begin
        mx_d = px_q;
        my_d = py_q;
        if (plast_q) begin
          cnt_d = 3'd0;
          out_d = '{out_x: px_q, out_y: py_q, out_last: 1'b1};
          state_d = (clos_q && cnt_q >= 3'd3) ? sce_pkg::S_CLA : sce_pkg::S_TAIL;
        end else begin
          cnt_d = (cnt_q >= 3'd4) ? 3'd4 : cnt_q + 3'd1;
          state_d = sce_pkg::S_IDLE;
        end
      end
      sce_pkg::S_CLA: begin
        acc_d = {1'b0, prod};
        state_d = far ? sce_pkg::S_TAIL : sce_pkg::S_CLB;
      end
      sce_pkg::S_CLB: begin
        acc_d = acc_q + {1'b0, prod};
        state_d = sce_pkg::S_CLC;
      end
      sce_pkg::S_CLC: begin
        if (acc_q < {1'b0, prod}) begin
          out_d = '{out_x: fx_q, out_y: fy_q, out_last: 1'b1};
        end
        state_d = sce_pkg::S_TAIL;
      end
      sce_pkg::S_TAIL: begin
        if (out_acc) state_d = sce_pkg::S_IDLE;
      end
      default: state_d = sce_pkg::S_IDLE;
    endcase
  end

  a_no_out_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o) else $error("output valid while taking input");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4) else $error("point count out of range");

  a_cordic_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cord_done |-> (state_q == sce_pkg::S_ANG1 || state_q == sce_pkg::S_ANG2))
    else $error("direction result outside angle states");

  a_tail_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sce_pkg::S_TAIL) |-> (cnt_q == 3'd0))
    else $error("stroke end without count clear");

endmodule
